[sv/coap_message_parser_assert.svh]
// Assertion macros for the CoAP message parser top level.
`ifndef COAP_MESSAGE_PARSER_ASSERT_SVH
`define COAP_MESSAGE_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked while rst_n is low.
`define COAP_MP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and masked while rst_n is low.
`define COAP_MP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/coap_mp_pkg.sv]
// Types, codes and helper functions for the CoAP message parser.
package coap_mp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TOKEN   = 3'd1,
        PH_OPT_HDR = 3'd2,
        PH_OPT_EXT = 3'd3,
        PH_OPT_VAL = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    localparam logic [2:0] CLS_HEADER  = 3'd0;
    localparam logic [2:0] CLS_TOKEN   = 3'd1;
    localparam logic [2:0] CLS_OPT_HDR = 3'd2;
    localparam logic [2:0] CLS_OPT_EXT = 3'd3;
    localparam logic [2:0] CLS_OPT_VAL = 3'd4;
    localparam logic [2:0] CLS_MARKER  = 3'd5;
    localparam logic [2:0] CLS_PAYLOAD = 3'd6;
    localparam logic [2:0] CLS_DISCARD = 3'd7;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT   = 3'd1;
    localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
    localparam logic [2:0] STATUS_BAD_TOKEN   = 3'd3;
    localparam logic [2:0] STATUS_BAD_OPTION  = 3'd4;
    localparam logic [2:0] STATUS_TOO_LONG    = 3'd5;

    localparam logic [15:0] MAX_BYTES_RESET = 16'd512;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [15:0] MIN_MSG_BYTES   = 16'd4;
    localparam logic [7:0]  PAYLOAD_MARKER  = 8'hFF;
    localparam logic [1:0]  COAP_VERSION    = 2'b01;
    localparam logic [3:0]  MAX_TOKEN_LEN   = 4'd8;
    localparam logic [3:0]  NIB_EXT1        = 4'd13;
    localparam logic [3:0]  NIB_EXT2        = 4'd14;
    localparam logic [3:0]  NIB_RESERVED    = 4'hF;
    localparam logic [16:0] EXT1_OFFSET     = 17'd13;
    localparam logic [16:0] EXT2_OFFSET     = 17'd269;

    // Per-datagram parsing context.
    typedef struct packed {
        logic [15:0] byte_count;
        phase_t      phase;
        logic [16:0] remaining_count;
        logic [1:0]  ext_bytes_left;
        logic [1:0]  len_ext_left;
        logic [3:0]  delta_nib;
        logic [3:0]  len_nib;
        logic [16:0] pending_delta;
        logic [15:0] current_option;
        logic [16:0] current_length;
        logic [31:0] header_fields;
        logic [2:0]  error_status;
    } state_t;

    // One tagged byte with the message fields seen so far.
    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  byte_class;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [7:0]  code;
        logic [15:0] message_id;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [2:0]  status;
        logic        end_of_message;
    } result_t;

    // Number of extension bytes that follow a delta or length nibble.
    function automatic logic [1:0] ext_count(input logic [3:0] nib);
        logic [1:0] cnt;
        if (nib == NIB_EXT1) begin
            cnt = 2'd1;
        end else if (nib == NIB_EXT2) begin
            cnt = 2'd2;
        end else begin
            cnt = 2'd0;
        end
        return cnt;
    endfunction

    // Value added once the extension bytes of a nibble are in.
    function automatic logic [16:0] ext_offset(input logic [3:0] nib);
        return (nib == NIB_EXT1) ? EXT1_OFFSET : EXT2_OFFSET;
    endfunction

endpackage

[sv/coap_message_parser.sv]
// Top level of the CoAP message parser: handshakes, registers and context.
//
// The parser takes a CoAP datagram as a stream of items, one byte per item,
// on the input channel (in_valid/in_ready, data_byte, last). For every byte
// it returns one item on the output channel (out_valid/out_ready) holding the
// byte, its role in the message, the header fields seen so far, the running
// option number and option length, and a status. The item for the byte
// marked last carries end_of_message and the final status; the parsing
// context then returns to its reset value for the next datagram.
//
// A byte accepted on the input channel is captured in the input register,
// and its result is loaded into the output register once that register is
// free or being emptied. Throughput is one item per cycle while the receiver
// keeps taking items; the per-byte context update is a single pass of logic
// between the two registers. When the receiver stalls, the result holds in
// the output register and the byte behind it waits in the input register;
// in_ready drops only when both are full. Reset clears both stages, the context
// and sets max_message_bytes to 512. The cfg channel is always ready; the user
// must write it only while the parser is idle; the block does not enforce it.
module coap_message_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_value,
    output logic [2:0]  byte_class,
    output logic [1:0]  version,
    output logic [1:0]  msg_type,
    output logic [3:0]  token_length,
    output logic [7:0]  code,
    output logic [15:0] message_id,
    output logic [15:0] option_number,
    output logic [15:0] option_length,
    output logic [2:0]  status,
    output logic        end_of_message,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import coap_mp_pkg::*;

    `include "coap_message_parser_assert.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    state_t      state_reg;
    state_t      state_next;
    logic [15:0] max_bytes_reg;
    logic        advance;
    logic        in_take;

    // The held byte moves on when the output register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    coap_mp_step u_step (
        .state_cur         (state_reg),
        .data_byte         (in_byte_reg),
        .last              (in_last_reg),
        .max_message_bytes (max_bytes_reg),
        .state_nxt         (state_next),
        .result            (result_next)
    );

    // Control state: stage valid flags, parsing context and the length limit.
    // The all-zero context is the header phase with nothing seen yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '0;
            max_bytes_reg   <= MAX_BYTES_RESET;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                max_bytes_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_byte_reg <= data_byte;
            in_last_reg <= last;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign byte_value     = result_reg.byte_value;
    assign byte_class     = result_reg.byte_class;
    assign version        = result_reg.version;
    assign msg_type       = result_reg.msg_type;
    assign token_length   = result_reg.token_length;
    assign code           = result_reg.code;
    assign message_id     = result_reg.message_id;
    assign option_number  = result_reg.option_number;
    assign option_length  = result_reg.option_length;
    assign status         = result_reg.status;
    assign end_of_message = result_reg.end_of_message;

    `COAP_MP_ASSERT_NEXT(a_result_loaded, advance, out_valid_reg,
        "processed item did not reach the output register")
    `COAP_MP_ASSERT_NEXT(a_held_byte_kept, in_valid_reg && !advance, in_valid_reg,
        "stalled input byte was dropped")
    `COAP_MP_ASSERT_NEXT(a_clear_after_last, advance && in_last_reg,
        state_reg.byte_count == 16'd0 && state_reg.error_status == STATUS_OK,
        "context not cleared after the last byte")
    `COAP_MP_ASSERT_NOW(a_discard_has_error, state_reg.phase == PH_DISCARD,
        state_reg.error_status != STATUS_OK,
        "discard phase without a latched error")
    `COAP_MP_ASSERT_NOW(a_discard_reports_error,
        out_valid_reg && result_reg.byte_class == CLS_DISCARD,
        result_reg.status != STATUS_OK,
        "discarded byte reported with ok status")

endmodule

[sv/coap_mp_step.sv]
// Next-context and result logic for one datagram byte.
module coap_mp_step (
    input  coap_mp_pkg::state_t  state_cur,
    input  logic [7:0]           data_byte,
    input  logic                 last,
    input  logic [15:0]          max_message_bytes,
    output coap_mp_pkg::state_t  state_nxt,
    output coap_mp_pkg::result_t result
);
    import coap_mp_pkg::*;

    state_t      nxt;
    logic [2:0]  cls;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        do_finish;
    logic [16:0] rem_dec;
    logic [17:0] opt_sum;
    logic [1:0]  ext_dec;
    logic [2:0]  status_val;
    logic        incomplete;

    always_comb
    begin
        nxt       = state_cur;
        cls       = CLS_DISCARD;
        fail_en   = 1'b0;
        fail_code = STATUS_OK;
        do_finish = 1'b0;
        rem_dec   = (state_cur.remaining_count != '0) ?
                    state_cur.remaining_count - 17'd1 : state_cur.remaining_count;
        ext_dec   = 2'd0;
        opt_sum   = '0;

        if (state_cur.phase != PH_DISCARD && state_cur.byte_count >= max_message_bytes) begin
            fail_en   = 1'b1;
            fail_code = STATUS_TOO_LONG;
        end else begin
            unique case (state_cur.phase)
                PH_HEADER:
                begin
                    cls = CLS_HEADER;
                    if (state_cur.byte_count == 16'd0) begin
                        nxt.header_fields = {data_byte, 24'd0};
                        if (data_byte[7:6] != COAP_VERSION) begin
                            fail_en   = 1'b1;
                            fail_code = STATUS_BAD_VERSION;
                        end else if (data_byte[3:0] > MAX_TOKEN_LEN) begin
                            fail_en   = 1'b1;
                            fail_code = STATUS_BAD_TOKEN;
                        end
                    end else if (state_cur.byte_count == 16'd1) begin
                        nxt.header_fields[23:16] = data_byte;
                    end else if (state_cur.byte_count == 16'd2) begin
                        nxt.header_fields[15:8] = data_byte;
                    end else begin
                        nxt.header_fields[7:0] = data_byte;
                        if (state_cur.header_fields[27:24] != 4'd0) begin
                            nxt.phase           = PH_TOKEN;
                            nxt.remaining_count = {13'd0, state_cur.header_fields[27:24]};
                        end else begin
                            nxt.phase = PH_OPT_HDR;
                        end
                    end
                end
                PH_TOKEN:
                begin
                    cls                 = CLS_TOKEN;
                    nxt.remaining_count = rem_dec;
                    if (rem_dec == '0) begin
                        nxt.phase = PH_OPT_HDR;
                    end
                end
                PH_OPT_HDR:
                begin
                    if (data_byte == PAYLOAD_MARKER) begin
                        cls                 = CLS_MARKER;
                        nxt.phase           = PH_PAYLOAD;
                        nxt.remaining_count = '0;
                    end else begin
                        cls           = CLS_OPT_HDR;
                        nxt.delta_nib = data_byte[7:4];
                        nxt.len_nib   = data_byte[3:0];
                        if (data_byte[7:4] == NIB_RESERVED || data_byte[3:0] == NIB_RESERVED) begin
                            fail_en   = 1'b1;
                            fail_code = STATUS_BAD_OPTION;
                        end else begin
                            nxt.ext_bytes_left = ext_count(data_byte[7:4]);
                            nxt.len_ext_left   = ext_count(data_byte[3:0]);
                            nxt.pending_delta  = (data_byte[7:4] < NIB_EXT1) ?
                                                 {13'd0, data_byte[7:4]} : 17'd0;
                            nxt.current_length = (data_byte[3:0] < NIB_EXT1) ?
                                                 {13'd0, data_byte[3:0]} : 17'd0;
                            if (nxt.ext_bytes_left != 2'd0 || nxt.len_ext_left != 2'd0) begin
                                nxt.phase = PH_OPT_EXT;
                            end else begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                end
                PH_OPT_EXT:
                begin
                    cls = CLS_OPT_EXT;
                    // Delta extension bytes come first, then length extension bytes.
                    if (state_cur.ext_bytes_left != 2'd0) begin
                        ext_dec            = state_cur.ext_bytes_left - 2'd1;
                        nxt.ext_bytes_left = ext_dec;
                        if (ext_dec == 2'd0) begin
                            nxt.pending_delta = {1'b0, state_cur.pending_delta[7:0], data_byte}
                                                + ext_offset(state_cur.delta_nib);
                        end else begin
                            nxt.pending_delta = {1'b0, state_cur.pending_delta[7:0], data_byte};
                        end
                    end else if (state_cur.len_ext_left != 2'd0) begin
                        ext_dec          = state_cur.len_ext_left - 2'd1;
                        nxt.len_ext_left = ext_dec;
                        if (ext_dec == 2'd0) begin
                            nxt.current_length = {1'b0, state_cur.current_length[7:0], data_byte}
                                                 + ext_offset(state_cur.len_nib);
                        end else begin
                            nxt.current_length = {1'b0, state_cur.current_length[7:0], data_byte};
                        end
                    end
                    if (nxt.ext_bytes_left == 2'd0 && nxt.len_ext_left == 2'd0) begin
                        do_finish = 1'b1;
                    end
                end
                PH_OPT_VAL:
                begin
                    cls                 = CLS_OPT_VAL;
                    nxt.remaining_count = rem_dec;
                    if (rem_dec == '0) begin
                        nxt.phase = PH_OPT_HDR;
                    end
                end
                PH_PAYLOAD:
                begin
                    cls                 = CLS_PAYLOAD;
                    nxt.remaining_count = 17'd1;
                end
                default:
                begin
                    cls = CLS_DISCARD;
                end
            endcase
        end

        // Option complete: add the delta to the running number, then go to
        // the value bytes or straight to the next option header.
        if (do_finish) begin
            opt_sum            = {2'b00, state_cur.current_option} + {1'b0, nxt.pending_delta};
            nxt.current_option = (opt_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : opt_sum[15:0];
            if (nxt.current_length == '0) begin
                nxt.phase = PH_OPT_HDR;
            end else begin
                nxt.phase           = PH_OPT_VAL;
                nxt.remaining_count = nxt.current_length;
            end
        end

        // The first error sticks; every later byte is discarded.
        if (fail_en) begin
            if (state_cur.error_status == STATUS_OK) begin
                nxt.error_status = fail_code;
            end
            nxt.phase = PH_DISCARD;
        end

        if (state_cur.byte_count != COUNT_MAX) begin
            nxt.byte_count = state_cur.byte_count + 16'd1;
        end

        incomplete = (nxt.phase == PH_TOKEN) || (nxt.phase == PH_OPT_EXT) ||
                     (nxt.phase == PH_OPT_VAL) ||
                     (nxt.phase == PH_PAYLOAD && nxt.remaining_count == '0);
        status_val = nxt.error_status;
        if (last) begin
            if (nxt.byte_count < MIN_MSG_BYTES) begin
                status_val = STATUS_TOO_SHORT;
            end else if (status_val == STATUS_OK && incomplete) begin
                status_val = STATUS_BAD_OPTION;
            end
        end

        result.byte_value     = data_byte;
        result.byte_class     = cls;
        result.version        = nxt.header_fields[31:30];
        result.msg_type       = nxt.header_fields[29:28];
        result.token_length   = nxt.header_fields[27:24];
        result.code           = nxt.header_fields[23:16];
        result.message_id     = nxt.header_fields[15:0];
        result.option_number  = nxt.current_option;
        result.option_length  = nxt.current_length[16] ? COUNT_MAX : nxt.current_length[15:0];
        result.status         = status_val;
        result.end_of_message = last;

        state_nxt = nxt;
        if (last) begin
            state_nxt       = '0;
            state_nxt.phase = PH_HEADER;
        end
    end

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the CoAP message parser: stimulus, predictor and checks.
module tb_top;

    import coap_mp_pkg::*;

    // The run stops here even if the parser hangs. A correct run sends about 1.4k
    // items, with random idle gaps on each side.
    localparam int unsigned CYCLE_LIMIT = 1000000;
    // Least number of bytes the random part sends for each register setting.
    localparam int unsigned BYTES_PER_SETTING = 200;
    // Margin waited after the last predicted result has come out, so that the
    // parser is idle before the next step.
    localparam int unsigned DRAIN_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  byte_value;
    logic [2:0]  byte_class;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [15:0] option_number;
    logic [15:0] option_length;
    logic [2:0]  status;
    logic        end_of_message;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;

    coap_message_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_value     (byte_value),
        .byte_class     (byte_class),
        .version        (version),
        .msg_type       (msg_type),
        .token_length   (token_length),
        .code           (code),
        .message_id     (message_id),
        .option_number  (option_number),
        .option_length  (option_length),
        .status         (status),
        .end_of_message (end_of_message),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // One row of the directed table. A row with a typed class and status has
    // those two fields filled in by hand. The predictor fills in all the
    // other fields.
    typedef struct {
        logic [7:0] b;
        logic       lst;
        bit         typed;
        logic [2:0] cls;
        logic [2:0] st;
    } dir_row_t;

    dir_row_t    dir_rows[$];
    result_t     tagged_bytes_due[$];   // predicted results, oldest first
    logic [7:0]  dgram[$];              // datagram being sent
    int unsigned send_idle = 14;        // upper bound of the sender's gap
    int unsigned ready_idle = 14;       // upper bound of the receiver's stall
    int unsigned errors = 0;
    int unsigned cycles = 0;

    // Copy of the parsing context that the predictor keeps.
    logic [15:0] max_len;
    logic [15:0] n_seen;
    phase_t      cur_phase;
    logic [16:0] bytes_to_go;
    logic [1:0]  dext_left;
    logic [1:0]  lext_left;
    logic [3:0]  dnib;
    logic [3:0]  lnib;
    logic [16:0] delta_acc;
    logic [15:0] opt_num;
    logic [16:0] opt_len;
    logic [31:0] hdr_word;
    logic [2:0]  err_code;

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("coap_message_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Put the context back to its state at reset, or after the last byte of
    // a datagram. The size register keeps its value.
    function automatic void clear_context();
        n_seen      = 16'd0;
        cur_phase   = PH_HEADER;
        bytes_to_go = 17'd0;
        dext_left   = 2'd0;
        lext_left   = 2'd0;
        dnib        = 4'd0;
        lnib        = 4'd0;
        delta_acc   = 17'd0;
        opt_num     = 16'd0;
        opt_len     = 17'd0;
        hdr_word    = 32'd0;
        err_code    = STATUS_OK;
    endfunction

    // Keep only the first error. After an error, every byte of the datagram
    // is discarded.
    function automatic void latch_error(input logic [2:0] st);
        if (err_code == STATUS_OK) begin
            err_code = st;
        end
        cur_phase = PH_DISCARD;
    endfunction

    function automatic logic [1:0] ext_len(input logic [3:0] nib);
        return (nib == NIB_EXT1) ? 2'd1 : ((nib == NIB_EXT2) ? 2'd2 : 2'd0);
    endfunction

    function automatic logic [16:0] ext_bias(input logic [3:0] nib);
        return (nib == NIB_EXT1) ? 17'd13 : 17'd269;
    endfunction

    // The option header is complete: add the delta to the option number,
    // which saturates, then go on to the option value or to the next header.
    function automatic void close_option();
        logic [17:0] total;
        total = {2'b00, opt_num} + {1'b0, delta_acc};
        opt_num = (total > 18'h0FFFF) ? 16'hFFFF : total[15:0];
        if (opt_len == 17'd0) begin
            cur_phase = PH_OPT_HDR;
        end else begin
            cur_phase = PH_OPT_VAL;
            bytes_to_go = opt_len;
        end
    endfunction

    // Work out the tagged result for one datagram byte and update the context.
    function automatic result_t parse_byte(input logic [7:0] b, input logic lst);
        result_t    r;
        logic [2:0] cls;
        logic [2:0] st;
        cls = CLS_DISCARD;
        if (cur_phase != PH_DISCARD && n_seen >= max_len) begin
            latch_error(STATUS_TOO_LONG);
        end else begin
            case (cur_phase)
                PH_HEADER:
                begin
                    cls = CLS_HEADER;
                    if (n_seen == 16'd0) begin
                        hdr_word = {b, 24'd0};
                        if (b[7:6] != COAP_VERSION) begin
                            latch_error(STATUS_BAD_VERSION);
                        end else if (b[3:0] > MAX_TOKEN_LEN) begin
                            latch_error(STATUS_BAD_TOKEN);
                        end
                    end else if (n_seen == 16'd1) begin
                        hdr_word[23:16] = b;
                    end else if (n_seen == 16'd2) begin
                        hdr_word[15:8] = b;
                    end else begin
                        hdr_word[7:0] = b;
                        if (hdr_word[27:24] != 4'd0) begin
                            cur_phase = PH_TOKEN;
                            bytes_to_go = {13'd0, hdr_word[27:24]};
                        end else begin
                            cur_phase = PH_OPT_HDR;
                        end
                    end
                end
                PH_TOKEN:
                begin
                    cls = CLS_TOKEN;
                    if (bytes_to_go != 17'd0) begin
                        bytes_to_go = bytes_to_go - 17'd1;
                    end
                    if (bytes_to_go == 17'd0) begin
                        cur_phase = PH_OPT_HDR;
                    end
                end
                PH_OPT_HDR:
                begin
                    if (b == PAYLOAD_MARKER) begin
                        cls = CLS_MARKER;
                        cur_phase = PH_PAYLOAD;
                        bytes_to_go = 17'd0;
                    end else begin
                        cls = CLS_OPT_HDR;
                        dnib = b[7:4];
                        lnib = b[3:0];
                        if (dnib == NIB_RESERVED || lnib == NIB_RESERVED) begin
                            latch_error(STATUS_BAD_OPTION);
                        end else begin
                            dext_left = ext_len(dnib);
                            lext_left = ext_len(lnib);
                            delta_acc = (dnib < NIB_EXT1) ? {13'd0, dnib} : 17'd0;
                            opt_len = (lnib < NIB_EXT1) ? {13'd0, lnib} : 17'd0;
                            if (dext_left != 2'd0 || lext_left != 2'd0) begin
                                cur_phase = PH_OPT_EXT;
                            end else begin
                                close_option();
                            end
                        end
                    end
                end
                PH_OPT_EXT:
                begin
                    // The delta extension bytes come first, then the length
                    // extension bytes. Both are big-endian.
                    cls = CLS_OPT_EXT;
                    if (dext_left != 2'd0) begin
                        delta_acc = {1'b0, delta_acc[7:0], b};
                        dext_left = dext_left - 2'd1;
                        if (dext_left == 2'd0) begin
                            delta_acc = delta_acc + ext_bias(dnib);
                        end
                    end else if (lext_left != 2'd0) begin
                        opt_len = {1'b0, opt_len[7:0], b};
                        lext_left = lext_left - 2'd1;
                        if (lext_left == 2'd0) begin
                            opt_len = opt_len + ext_bias(lnib);
                        end
                    end
                    if (dext_left == 2'd0 && lext_left == 2'd0) begin
                        close_option();
                    end
                end
                PH_OPT_VAL:
                begin
                    cls = CLS_OPT_VAL;
                    if (bytes_to_go != 17'd0) begin
                        bytes_to_go = bytes_to_go - 17'd1;
                    end
                    if (bytes_to_go == 17'd0) begin
                        cur_phase = PH_OPT_HDR;
                    end
                end
                PH_PAYLOAD:
                begin
                    // Record that a payload byte came after the marker.
                    cls = CLS_PAYLOAD;
                    bytes_to_go = 17'd1;
                end
                default:
                begin
                    cls = CLS_DISCARD;
                end
            endcase
        end

        if (n_seen != COUNT_MAX) begin
            n_seen = n_seen + 16'd1;
        end

        // Final status. A short datagram overrides any other error. A
        // datagram that ends in the middle of a part is truncated.
        st = err_code;
        if (lst) begin
            if (n_seen < MIN_MSG_BYTES) begin
                st = STATUS_TOO_SHORT;
            end else if (st == STATUS_OK) begin
                if (cur_phase == PH_TOKEN || cur_phase == PH_OPT_EXT ||
                    cur_phase == PH_OPT_VAL ||
                    (cur_phase == PH_PAYLOAD && bytes_to_go == 17'd0)) begin
                    st = STATUS_BAD_OPTION;
                end
            end
        end

        r.byte_value     = b;
        r.byte_class     = cls;
        r.version        = hdr_word[31:30];
        r.msg_type       = hdr_word[29:28];
        r.token_length   = hdr_word[27:24];
        r.code           = hdr_word[23:16];
        r.message_id     = hdr_word[15:0];
        r.option_number  = opt_num;
        r.option_length  = (opt_len > 17'h0FFFF) ? 16'hFFFF : opt_len[15:0];
        r.status         = st;
        r.end_of_message = lst;

        if (lst) begin
            clear_context();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void row_checked(input logic [7:0] b, input logic lst);
        dir_rows.push_back('{b, lst, 1'b0, CLS_DISCARD, STATUS_OK});
    endfunction

    function automatic void row_typed(input logic [7:0] b, input logic lst,
                                      input logic [2:0] cls, input logic [2:0] st);
        dir_rows.push_back('{b, lst, 1'b1, cls, st});
    endfunction

    // Offer one byte after a random gap and hold it until the parser takes
    // it. Return the predicted result for that byte. The task is called just
    // after a rising edge, and it returns just after the edge at which the
    // byte was taken.
    task automatic send_byte(input logic [7:0] b, input logic lst, output result_t want);
        int unsigned gap;
        gap = $urandom_range(send_idle, 0);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= lst;
        do @(posedge clk); while (!in_ready);
        want = parse_byte(b, lst);
    endtask

    // Send the bytes in dgram in order. The last one carries the last flag.
    task automatic send_dgram();
        result_t want;
        for (int i = 0; i < dgram.size(); i++) begin
            send_byte(dgram[i], i == dgram.size() - 1, want);
            tagged_bytes_due.push_back(want);
        end
    endtask

    // Stop offering bytes and wait for every predicted result to come out.
    // Then wait out the DRAIN_CYCLES margin so that the parser is idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tagged_bytes_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the size register. The predictor uses the new value from this
    // point on.
    task automatic write_max_len(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len = v;
    endtask

    // Build a random datagram in dgram. Most datagrams are well formed: a
    // header, a token, options with random deltas and extension bytes, and an
    // optional payload. Some are only noise. Some are cut short or have one
    // byte overwritten. An option whose value is long is cut short, so that
    // most datagrams stay small.
    function automatic void build_datagram();
        int unsigned kind;
        int unsigned n_opt;
        int unsigned vlen;
        logic [3:0]  tkl;
        logic [1:0]  mt;
        logic [3:0]  dn;
        logic [3:0]  ln;
        logic [7:0]  hi;
        logic [7:0]  lo;
        bit          cut;
        dgram.delete();
        kind = $urandom_range(99, 0);
        if (kind < 8) begin
            repeat ($urandom_range(12, 1)) dgram.push_back(8'($urandom_range(255, 0)));
            return;
        end
        tkl = 4'($urandom_range(8, 0));
        mt = 2'($urandom_range(3, 0));
        dgram.push_back({COAP_VERSION, mt, tkl});
        repeat (3) dgram.push_back(8'($urandom_range(255, 0)));
        repeat (tkl) dgram.push_back(8'($urandom_range(255, 0)));

        n_opt = $urandom_range(4, 0);
        cut = 1'b0;
        for (int k = 0; k < n_opt && !cut; k++) begin
            dn = ($urandom_range(3, 0) == 0) ? 4'(NIB_EXT1 + $urandom_range(1, 0))
                                              : 4'($urandom_range(12, 0));
            if ($urandom_range(9, 0) == 0) begin
                ln = NIB_EXT2;
            end else if ($urandom_range(5, 0) == 0) begin
                ln = NIB_EXT1;
            end else begin
                ln = 4'($urandom_range(6, 0));
            end
            // A reserved nibble now and then.
            if ($urandom_range(24, 0) == 0) begin
                if ($urandom_range(1, 0) == 0) begin
                    dn = NIB_RESERVED;
                end else begin
                    ln = NIB_RESERVED;
                end
            end
            dgram.push_back({dn, ln});

            if (dn == NIB_EXT1) begin
                dgram.push_back(8'($urandom_range(255, 0)));
            end else if (dn == NIB_EXT2) begin
                // All-ones extension bytes make the option number saturate.
                hi = ($urandom_range(3, 0) == 0) ? 8'hFF : 8'($urandom_range(255, 0));
                lo = ($urandom_range(3, 0) == 0) ? 8'hFF : 8'($urandom_range(255, 0));
                dgram.push_back(hi);
                dgram.push_back(lo);
            end

            vlen = 32'(ln);
            if (ln == NIB_EXT1) begin
                lo = ($urandom_range(7, 0) == 0) ? 8'hFF : 8'($urandom_range(12, 0));
                dgram.push_back(lo);
                vlen = 13 + lo;
            end else if (ln == NIB_EXT2) begin
                hi = ($urandom_range(3, 0) == 0) ? 8'hFF : 8'($urandom_range(255, 0));
                lo = ($urandom_range(3, 0) == 0) ? 8'hFF : 8'($urandom_range(255, 0));
                dgram.push_back(hi);
                dgram.push_back(lo);
                vlen = 269 + {hi, lo};
            end
            if (vlen > 24) begin
                vlen = $urandom_range(6, 0);
                cut = 1'b1;
            end
            repeat (vlen) dgram.push_back(8'($urandom_range(255, 0)));
        end

        // A payload marker, sometimes with no payload after it.
        if (!cut && $urandom_range(2, 0) != 0) begin
            dgram.push_back(PAYLOAD_MARKER);
            repeat ($urandom_range(8, 0)) dgram.push_back(8'($urandom_range(255, 0)));
        end

        // Broken sequences: cut short, or one byte overwritten.
        kind = $urandom_range(9, 0);
        if (kind == 0) begin
            while (dgram.size() > 1 && $urandom_range(3, 0) != 0) void'(dgram.pop_back());
        end else if (kind == 1) begin
            dgram[$urandom_range(dgram.size() - 1, 0)] = 8'($urandom_range(255, 0));
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endfunction

    // The receiver. It stalls for a random number of cycles before each
    // item, then takes the item. It checks each item against the oldest
    // predicted result.
    initial begin
        int unsigned stall;
        result_t     want;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = $urandom_range(ready_idle, 0);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (tagged_bytes_due.size() == 0) begin
                errors++;
                $display("%0t: item with no prediction, expected none, actual byte %0d",
                         $time, byte_value);
            end else begin
                want = tagged_bytes_due.pop_front();
                check_field("byte_value", 32'(want.byte_value), 32'(byte_value));
                check_field("byte_class", 32'(want.byte_class), 32'(byte_class));
                check_field("version", 32'(want.version), 32'(version));
                check_field("msg_type", 32'(want.msg_type), 32'(msg_type));
                check_field("token_length", 32'(want.token_length), 32'(token_length));
                check_field("code", 32'(want.code), 32'(code));
                check_field("message_id", 32'(want.message_id), 32'(message_id));
                check_field("option_number", 32'(want.option_number),
                            32'(option_number));
                check_field("option_length", 32'(want.option_length),
                            32'(option_length));
                check_field("status", 32'(want.status), 32'(status));
                check_field("end_of_message", 32'(want.end_of_message),
                            32'(end_of_message));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        result_t     want;
        int unsigned sent;
        logic [15:0] limit;

        max_len = MAX_BYTES_RESET;
        clear_context();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. It runs with the size register at its reset value.
        // A single byte is too short.
        row_typed(8'h40, 1'b1, CLS_HEADER, STATUS_TOO_SHORT);
        // An all-ones first byte has version 3. The bad version is checked
        // before the token length. Every later byte is discarded and the
        // error stays.
        row_typed(8'hFF, 1'b0, CLS_HEADER, STATUS_BAD_VERSION);
        row_typed(8'hFF, 1'b0, CLS_DISCARD, STATUS_BAD_VERSION);
        row_typed(8'h00, 1'b0, CLS_DISCARD, STATUS_BAD_VERSION);
        row_typed(8'h00, 1'b1, CLS_DISCARD, STATUS_BAD_VERSION);
        // A token length of 9 is an error. The datagram then ends after two
        // bytes, so the status on the last byte is too short instead.
        row_typed(8'h49, 1'b0, CLS_HEADER, STATUS_BAD_TOKEN);
        row_typed(8'h00, 1'b1, CLS_DISCARD, STATUS_TOO_SHORT);
        // A well-formed start: a header, one token byte, and an option with a
        // one-byte delta extension and a one-byte value. Then an option with
        // a two-byte delta extension of all ones, which makes the option
        // number saturate. Then a payload marker with no payload after it.
        row_checked(8'h41, 1'b0);
        row_checked(8'h01, 1'b0);
        row_checked(8'h12, 1'b0);
        row_checked(8'h34, 1'b0);
        row_checked(8'hAA, 1'b0);
        row_checked(8'hD1, 1'b0);
        row_checked(8'h00, 1'b0);
        row_checked(8'h55, 1'b0);
        row_checked(8'hE0, 1'b0);
        row_checked(8'hFF, 1'b0);
        row_checked(8'hFF, 1'b0);
        row_typed(8'hFF, 1'b1, CLS_MARKER, STATUS_BAD_OPTION);
        // A header with version 1 and all other fields zero, then an option header
        // whose length nibble is reserved.
        row_checked(8'h40, 1'b0);
        row_checked(8'h00, 1'b0);
        row_checked(8'h00, 1'b0);
        row_checked(8'h00, 1'b0);
        row_typed(8'h0F, 1'b1, CLS_OPT_HDR, STATUS_BAD_OPTION);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].b, dir_rows[i].lst, want);
            if (dir_rows[i].typed) begin
                want.byte_class = dir_rows[i].cls;
                want.status = dir_rows[i].st;
            end
            tagged_bytes_due.push_back(want);
        end
        wait_drained();

        // Random datagrams, one block of them for each size setting. Some
        // blocks run with no idling on one side or on both.
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin limit = 16'd4;                         send_idle = 14; ready_idle = 14; end
                1: begin limit = 16'hFFFF;                      send_idle = 14; ready_idle = 14; end
                2: begin limit = 16'($urandom_range(40, 5));    send_idle = 0;  ready_idle = 0;  end
                3: begin limit = MAX_BYTES_RESET;               send_idle = 14; ready_idle = 0;  end
                4: begin limit = 16'($urandom_range(65534, 41)); send_idle = 0; ready_idle = 14; end
                5: begin limit = 16'($urandom_range(40, 5));    send_idle = 14; ready_idle = 14; end
                default: begin limit = 16'($urandom_range(600, 60)); send_idle = 14; ready_idle = 14; end
            endcase
            write_max_len(limit);
            sent = 0;
            while (sent < BYTES_PER_SETTING) begin
                build_datagram();
                sent += dgram.size();
                send_dgram();
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("coap_message_parser regression: pass");
        end else begin
            $display("coap_message_parser regression: fail");
        end
        $finish;
    end

endmodule
